@@ rtl/core/mft_pkg.sv @@
// Shared types and constants of the multi-turn motor feedback tracker.
`default_nettype none
package mft_pkg;

    localparam int NUM_MOTORS    = 4;
    localparam int MOTOR_IDX_W   = 2;
    localparam int ID_W          = 11;
    localparam int POS_W         = 13;
    localparam int WORD_W        = 16;
    localparam int CPOS_W        = 29;
    localparam int SANGLE_W      = 15;
    localparam int CANGLE_W      = 31;
    localparam int CFG_INDEX_W   = 4;
    localparam int PROD_W        = 44;
    localparam int REM_W         = 16;

    localparam int WRAP_HALF       = 4096;
    localparam int COUNTS_PER_TURN = 8191;
    localparam int TURN_SHIFT      = 13;     // 8191 = 2^13 - 1
    localparam int ANGLE_SCALE     = 23040;  // 360 * 64

    // pipeline depth of the angle scaler
    localparam int SCALE_LAT = 4;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 8;

    localparam logic [ID_W-1:0] MOTOR_ID_RESET [NUM_MOTORS] = '{
        ID_W'(513), ID_W'(514), ID_W'(515), ID_W'(516)
    };

    // classified frame, front to back
    typedef struct packed {
        logic [MOTOR_IDX_W-1:0] motor_index;
        logic [POS_W-1:0]       position;
        logic [WORD_W-1:0]      speed;
        logic [WORD_W-1:0]      current;
    } mid_item_t;

    // frame after the turn count update
    typedef struct packed {
        logic [MOTOR_IDX_W-1:0] motor_index;
        logic [POS_W-1:0]       position;
        logic [WORD_W-1:0]      speed;
        logic [WORD_W-1:0]      current;
        logic [WORD_W-1:0]      turn_count;
    } pipe_item_t;

    typedef struct packed {
        logic [MOTOR_IDX_W-1:0] motor_index;
        logic [POS_W-1:0]       position;
        logic [WORD_W-1:0]      speed;
        logic [WORD_W-1:0]      current;
        logic [WORD_W-1:0]      turn_count;
        logic [CPOS_W-1:0]      continuous_position;
        logic [SANGLE_W-1:0]    single_angle;
        logic [CANGLE_W-1:0]    continuous_angle;
    } out_item_t;

endpackage
`default_nettype wire

@@ rtl/core/mft_fifo.sv @@
// Small register queue with occupancy count.
`default_nettype none
module mft_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           din,
    output logic                            full,
    input  wire logic                       pop,
    output logic [WIDTH-1:0]                dout,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mft_front.sv @@
// Front end: motor ID registers and frame classification.
`default_nettype none
module mft_front
    import mft_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ID_W-1:0]        cfg_data,
    input  wire logic                   push,
    input  wire logic                   full,
    input  wire logic [ID_W-1:0]        frame_id,
    input  wire logic [POS_W-1:0]       encoder_position,
    input  wire logic signed [WORD_W-1:0] motor_speed,
    input  wire logic signed [WORD_W-1:0] motor_current,
    output logic                        mid_push,
    output mid_item_t                   mid_item
);

    logic [ID_W-1:0]        motor_id_reg [NUM_MOTORS];
    logic                   hit;
    logic [MOTOR_IDX_W-1:0] hit_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                motor_id_reg[i] <= MOTOR_ID_RESET[i];
            end
        end
        else if (cfg_valid && (cfg_index < CFG_INDEX_W'(NUM_MOTORS)))
        begin
            motor_id_reg[cfg_index[MOTOR_IDX_W-1:0]] <= cfg_data;
        end
    end

    // lowest matching motor wins
    always_comb
    begin
        hit       = 1'b0;
        hit_index = '0;
        for (int i = NUM_MOTORS - 1; i >= 0; i--)
        begin
            if (motor_id_reg[i] == frame_id)
            begin
                hit       = 1'b1;
                hit_index = MOTOR_IDX_W'(i);
            end
        end
    end

    assign mid_push             = push && !full && hit;
    assign mid_item.motor_index = hit_index;
    assign mid_item.position    = encoder_position;
    assign mid_item.speed       = motor_speed;
    assign mid_item.current     = motor_current;

endmodule
`default_nettype wire

@@ rtl/core/mft_scale.sv @@
// Pipelined signed scaling by 23040/8191, truncated toward zero.
`default_nettype none
module mft_scale
    import mft_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic signed [CPOS_W-1:0]   value,
    output logic signed [CANGLE_W-1:0]      result
);

    localparam int QW = CANGLE_W;

    logic                s1_sign_reg, s2_sign_reg, s3_sign_reg;
    logic [PROD_W-1:0]   s1_prod_reg, s2_prod_reg;
    logic [QW-1:0]       s2_q0_reg, s3_q0_reg;
    logic [REM_W-1:0]    s3_rem_reg;
    logic [QW-1:0]       result_reg;

    logic [CPOS_W-1:0]   mag;
    logic [PROD_W-1:0]   prod;
    logic [QW-1:0]       q0;
    logic [PROD_W-1:0]   rem_full;
    logic [1:0]          corr;
    logic [QW-1:0]       base;
    logic [QW-1:0]       addend;

    always_comb
    begin
        mag  = value[CPOS_W-1] ? CPOS_W'(-value) : CPOS_W'(value);
        prod = PROD_W'(mag) * PROD_W'(ANGLE_SCALE);
    end

    // 1/8191 = 2^-13 + 2^-26 + 2^-39 + ...; estimate sits at most 3 low
    always_comb
    begin
        q0 = QW'(s1_prod_reg >> TURN_SHIFT)
           + QW'(s1_prod_reg >> (2 * TURN_SHIFT))
           + QW'(s1_prod_reg >> (3 * TURN_SHIFT));
    end

    always_comb
    begin
        rem_full = s2_prod_reg - (PROD_W'(s2_q0_reg) << TURN_SHIFT) + PROD_W'(s2_q0_reg);
    end

    // negative: -(q0 + corr) = ~q0 + 1 - corr
    always_comb
    begin
        corr = 2'(s3_rem_reg >= REM_W'(COUNTS_PER_TURN))
             + 2'(s3_rem_reg >= REM_W'(2 * COUNTS_PER_TURN))
             + 2'(s3_rem_reg >= REM_W'(3 * COUNTS_PER_TURN));
        base   = s3_sign_reg ? ~s3_q0_reg : s3_q0_reg;
        addend = s3_sign_reg ? (QW'(1) - QW'(corr)) : QW'(corr);
    end

    always_ff @(posedge clk)
    begin
        s1_sign_reg <= value[CPOS_W-1];
        s1_prod_reg <= prod;
        s2_sign_reg <= s1_sign_reg;
        s2_prod_reg <= s1_prod_reg;
        s2_q0_reg   <= q0;
        s3_sign_reg <= s2_sign_reg;
        s3_q0_reg   <= s2_q0_reg;
        s3_rem_reg  <= rem_full[REM_W-1:0];
        result_reg  <= base + addend;
    end

    assign result = $signed(result_reg);

endmodule
`default_nettype wire

@@ rtl/core/mft_back.sv @@
// Back end: per-motor turn tracking, continuous position and angle pipeline.
`default_nettype none
module mft_back
    import mft_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           mid_empty,
    input  wire mid_item_t                      mid_item,
    output logic                                mid_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                                out_push,
    output out_item_t                           out_item
);

    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam logic signed [POS_W:0] WRAP_POS = (POS_W + 1)'(WRAP_HALF);
    localparam logic signed [POS_W:0] WRAP_NEG = -WRAP_POS;
    localparam logic signed [WORD_W-1:0] TC_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] TC_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic [POS_W-1:0]         last_pos_reg [NUM_MOTORS];
    logic signed [WORD_W-1:0] turn_reg     [NUM_MOTORS];
    logic [CW-1:0]            inflight_reg, inflight_next;

    logic                     a_valid_reg;
    pipe_item_t               a_item_reg;
    logic                     b_valid_reg;
    pipe_item_t               b_item_reg;
    logic signed [CPOS_W-1:0] b_cpos_reg;
    logic                     d_valid_reg [SCALE_LAT];
    pipe_item_t               d_item_reg  [SCALE_LAT];
    logic [CPOS_W-1:0]        d_cpos_reg  [SCALE_LAT];

    logic signed [POS_W:0]    diff;
    logic signed [WORD_W-1:0] tc_old, tc_new;
    logic signed [CPOS_W-1:0] tc_ext, cpos;
    logic signed [CPOS_W-1:0] single_in;
    logic signed [CANGLE_W-1:0] single_q, cont_q;
    logic [CW:0]              occupancy;

    // credit: everything in flight has a slot reserved in the output queue
    assign occupancy = (CW + 1)'(out_count) + (CW + 1)'(inflight_reg);
    assign mid_pop   = !mid_empty && (occupancy < (CW + 1)'(OUT_DEPTH));
    assign out_push  = d_valid_reg[SCALE_LAT-1];

    always_comb
    begin
        inflight_next = inflight_reg;
        if (mid_pop && !out_push)
        begin
            inflight_next = inflight_reg + CW'(1);
        end
        else if (out_push && !mid_pop)
        begin
            inflight_next = inflight_reg - CW'(1);
        end
    end

    // jump of exactly half a turn is not a wrap
    always_comb
    begin
        diff   = $signed({1'b0, mid_item.position})
               - $signed({1'b0, last_pos_reg[mid_item.motor_index]});
        tc_old = turn_reg[mid_item.motor_index];
        tc_new = tc_old;
        priority if (diff > WRAP_POS)
        begin
            if (tc_old != TC_MIN)
            begin
                tc_new = tc_old - WORD_W'(1);
            end
        end
        else if (diff < WRAP_NEG)
        begin
            if (tc_old != TC_MAX)
            begin
                tc_new = tc_old + WORD_W'(1);
            end
        end
        else
        begin
            tc_new = tc_old;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                last_pos_reg[i] <= '0;
                turn_reg[i]     <= '0;
            end
            inflight_reg <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            for (int i = 0; i < SCALE_LAT; i++)
            begin
                d_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (mid_pop)
            begin
                last_pos_reg[mid_item.motor_index] <= mid_item.position;
                turn_reg[mid_item.motor_index]     <= tc_new;
            end
            inflight_reg   <= inflight_next;
            a_valid_reg    <= mid_pop;
            b_valid_reg    <= a_valid_reg;
            d_valid_reg[0] <= b_valid_reg;
            for (int i = 1; i < SCALE_LAT; i++)
            begin
                d_valid_reg[i] <= d_valid_reg[i-1];
            end
        end
    end

    // position + turns * (2^13 - 1)
    always_comb
    begin
        tc_ext = CPOS_W'($signed(a_item_reg.turn_count));
        cpos   = (tc_ext <<< TURN_SHIFT) - tc_ext
               + $signed(CPOS_W'(a_item_reg.position));
    end

    always_ff @(posedge clk)
    begin
        a_item_reg.motor_index <= mid_item.motor_index;
        a_item_reg.position    <= mid_item.position;
        a_item_reg.speed       <= mid_item.speed;
        a_item_reg.current     <= mid_item.current;
        a_item_reg.turn_count  <= tc_new;
        b_item_reg             <= a_item_reg;
        b_cpos_reg             <= cpos;
        d_item_reg[0]          <= b_item_reg;
        d_cpos_reg[0]          <= b_cpos_reg;
        for (int i = 1; i < SCALE_LAT; i++)
        begin
            d_item_reg[i] <= d_item_reg[i-1];
            d_cpos_reg[i] <= d_cpos_reg[i-1];
        end
    end

    assign single_in = $signed(CPOS_W'(b_item_reg.position));

    mft_scale u_scale_cont (
        .clk    (clk),
        .value  (b_cpos_reg),
        .result (cont_q)
    );

    mft_scale u_scale_single (
        .clk    (clk),
        .value  (single_in),
        .result (single_q)
    );

    assign out_item.motor_index         = d_item_reg[SCALE_LAT-1].motor_index;
    assign out_item.position            = d_item_reg[SCALE_LAT-1].position;
    assign out_item.speed               = d_item_reg[SCALE_LAT-1].speed;
    assign out_item.current             = d_item_reg[SCALE_LAT-1].current;
    assign out_item.turn_count          = d_item_reg[SCALE_LAT-1].turn_count;
    assign out_item.continuous_position = d_cpos_reg[SCALE_LAT-1];
    assign out_item.single_angle        = single_q[SANGLE_W-1:0];
    assign out_item.continuous_angle    = cont_q;

endmodule
`default_nettype wire

@@ rtl/core/motor_feedback_multiturn_tracker.sv @@
// Top level of the multi-turn motor feedback tracker.
// Takes one feedback frame per clock while full is low and, for frames whose
// identifier matches one of four programmed motor IDs, returns the updated
// turn count, the continuous position and both angles in 1/64 degree; other
// frames are dropped. A frame's result reaches the output queue through the
// classification queue, the turn update, the continuous position add and the
// four-stage angle scaler. Each motor's position and turn count are read and
// written in the same cycle, so frames of the same motor may follow each other
// back to back. The back end only starts a frame when the output queue has a
// slot for it, so the input keeps flowing at one frame per cycle while the
// output queue (OUT_DEPTH entries, at least the six pipeline stages plus two)
// has room.
`default_nettype none
module motor_feedback_multiturn_tracker
    import mft_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [ID_W-1:0]            cfg_data,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [ID_W-1:0]            frame_id,
    input  wire logic [POS_W-1:0]           encoder_position,
    input  wire logic signed [WORD_W-1:0]   motor_speed,
    input  wire logic signed [WORD_W-1:0]   motor_current,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [MOTOR_IDX_W-1:0]          motor_index,
    output logic [POS_W-1:0]                position_out,
    output logic signed [WORD_W-1:0]        speed_out,
    output logic signed [WORD_W-1:0]        current_out,
    output logic signed [WORD_W-1:0]        turn_count_out,
    output logic signed [CPOS_W-1:0]        continuous_position,
    output logic [SANGLE_W-1:0]             single_angle,
    output logic signed [CANGLE_W-1:0]      continuous_angle
);

    localparam int MID_W = $bits(mid_item_t);
    localparam int OUT_W = $bits(out_item_t);

    logic                            mid_push, mid_pop, mid_full, mid_empty;
    mid_item_t                       mid_in, mid_out;
    logic [$clog2(MID_DEPTH+1)-1:0]  mid_count;
    logic                            out_push, out_full;
    out_item_t                       out_in, out_head;
    logic [$clog2(OUT_DEPTH+1)-1:0]  out_count;

    assign cfg_ready = 1'b1;
    assign full      = mid_full;

    mft_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .push             (push),
        .full             (mid_full),
        .frame_id         (frame_id),
        .encoder_position (encoder_position),
        .motor_speed      (motor_speed),
        .motor_current    (motor_current),
        .mid_push         (mid_push),
        .mid_item         (mid_in)
    );

    mft_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_in),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_out),
        .empty (mid_empty),
        .count (mid_count)
    );

    mft_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty && (mid_count == '0)),
        .mid_item  (mid_out),
        .mid_pop   (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_item  (out_in)
    );

    // room is reserved by the back end's credit, so out_full never blocks
    mft_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push && !out_full),
        .din   (out_in),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_head),
        .empty (empty),
        .count (out_count)
    );

    assign motor_index         = out_head.motor_index;
    assign position_out        = out_head.position;
    assign speed_out           = out_head.speed;
    assign current_out         = out_head.current;
    assign turn_count_out      = out_head.turn_count;
    assign continuous_position = out_head.continuous_position;
    assign single_angle        = out_head.single_angle;
    assign continuous_angle    = out_head.continuous_angle;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench of the multi-turn motor feedback tracker.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mft_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR0_ID = 0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR1_ID = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR2_ID = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR3_ID = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT     = 4;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_RESULTS  = 130;
    localparam int SPIN_TURNS     = 40;

    localparam int TURN_MIN = -32768;
    localparam int TURN_MAX = 32767;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] speed;
        logic signed [WORD_W-1:0] current;
    } frame_t;

    typedef struct packed {
        logic [MOTOR_IDX_W-1:0]   motor;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] speed;
        logic signed [WORD_W-1:0] current;
        logic signed [WORD_W-1:0] turns;
        logic signed [CPOS_W-1:0] cpos;
        logic [SANGLE_W-1:0]      sangle;
        logic signed [CANGLE_W-1:0] cangle;
    } result_t;

    class unwrap_scoreboard;
        logic [ID_W-1:0]          motor_id [NUM_MOTORS];
        logic [POS_W-1:0]         last_pos [NUM_MOTORS];
        logic signed [WORD_W-1:0] turns    [NUM_MOTORS];
        result_t                  expected_results [$];
        int errors;
        int frames;
        int dropped;
        int checked;
        int reg_writes;
        int min_turns;
        int max_turns;

        function new();
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                motor_id[i] = MOTOR_ID_RESET[i];
                last_pos[i] = '0;
                turns[i]    = '0;
            end
            errors     = 0;
            frames     = 0;
            dropped    = 0;
            checked    = 0;
            reg_writes = 0;
            min_turns  = 0;
            max_turns  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ID_W-1:0] val);
            reg_writes++;
            if (idx < REG_COUNT)
                motor_id[idx] = val;
        endfunction

        // lowest matching motor wins; updates that motor's unwrap state
        function bit unwrap_frame(frame_t f, output result_t r);
            int     m;
            int     diff;
            int     tc;
            longint cpos;
            longint mag;
            longint sa;
            m = -1;
            r = '0;
            for (int i = NUM_MOTORS - 1; i >= 0; i--)
                if (motor_id[i] == f.id)
                    m = i;
            if (m < 0)
                return 1'b0;
            diff = int'(f.pos) - int'(last_pos[m]);
            tc   = turns[m];
            if (diff > WRAP_HALF)
            begin
                if (tc > TURN_MIN)
                    tc--;
            end
            else if (diff < -WRAP_HALF)
            begin
                if (tc < TURN_MAX)
                    tc++;
            end
            turns[m]    = tc[WORD_W-1:0];
            last_pos[m] = f.pos;
            if (tc < min_turns)
                min_turns = tc;
            if (tc > max_turns)
                max_turns = tc;
            cpos = longint'(f.pos) + longint'(tc) * COUNTS_PER_TURN;
            sa   = longint'(f.pos) * ANGLE_SCALE / COUNTS_PER_TURN;
            mag  = (cpos < 0) ? -cpos : cpos;
            mag  = mag * ANGLE_SCALE / COUNTS_PER_TURN;
            if (cpos < 0)
                mag = -mag;
            r.motor   = m[MOTOR_IDX_W-1:0];
            r.pos     = f.pos;
            r.speed   = f.speed;
            r.current = f.current;
            r.turns   = tc[WORD_W-1:0];
            r.cpos    = cpos[CPOS_W-1:0];
            r.sangle  = sa[SANGLE_W-1:0];
            r.cangle  = mag[CANGLE_W-1:0];
            return 1'b1;
        endfunction

        function void note_frame(frame_t f);
            result_t r;
            frames++;
            if (unwrap_frame(f, r))
                expected_results.push_back(r);
            else
                dropped++;
        endfunction

        function void compare(string name, logic signed [63:0] e, logic signed [63:0] a);
            if (a !== e)
            begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(result_t a);
            result_t e;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: motor_index %0d position_out %0d", a.motor, a.pos);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            checked++;
            compare("motor_index", e.motor, a.motor);
            compare("position_out", e.pos, a.pos);
            compare("speed_out", e.speed, a.speed);
            compare("current_out", e.current, a.current);
            compare("turn_count_out", e.turns, a.turns);
            compare("continuous_position", e.cpos, a.cpos);
            compare("single_angle", e.sangle, a.sangle);
            compare("continuous_angle", e.cangle, a.cangle);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [ID_W-1:0]            cfg_data = '0;
    logic                       push = 1'b0;
    logic                       full;
    logic [ID_W-1:0]            frame_id = '0;
    logic [POS_W-1:0]           encoder_position = '0;
    logic signed [WORD_W-1:0]   motor_speed = '0;
    logic signed [WORD_W-1:0]   motor_current = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [MOTOR_IDX_W-1:0]     motor_index;
    logic [POS_W-1:0]           position_out;
    logic signed [WORD_W-1:0]   speed_out;
    logic signed [WORD_W-1:0]   current_out;
    logic signed [WORD_W-1:0]   turn_count_out;
    logic signed [CPOS_W-1:0]   continuous_position;
    logic [SANGLE_W-1:0]        single_angle;
    logic signed [CANGLE_W-1:0] continuous_angle;

    unwrap_scoreboard sb = new();

    bit calm     = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;
    bit holding  = 1'b0;
    int settings = 1;
    int quiet_cycles = 0;

    motor_feedback_multiturn_tracker u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .push                (push),
        .full                (full),
        .frame_id            (frame_id),
        .encoder_position    (encoder_position),
        .motor_speed         (motor_speed),
        .motor_current       (motor_current),
        .empty               (empty),
        .pop                 (pop),
        .motor_index         (motor_index),
        .position_out        (position_out),
        .speed_out           (speed_out),
        .current_out         (current_out),
        .turn_count_out      (turn_count_out),
        .continuous_position (continuous_position),
        .single_angle        (single_angle),
        .continuous_angle    (continuous_angle)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // transfer monitors
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (push && !full)
                sb.note_frame('{frame_id, encoder_position, motor_speed, motor_current});
            if (pop && !empty)
                sb.check_result('{motor_index, position_out, speed_out, current_out,
                                  turn_count_out, continuous_position, single_angle,
                                  continuous_angle});
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                pop      <= 1'b0;
                holding   = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding   = 1'b0;
                hold_req  = 1'b0;
            end
            else if (calm)
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic send(input logic [ID_W-1:0] id, input logic [POS_W-1:0] pos,
                        input logic signed [WORD_W-1:0] spd, input logic signed [WORD_W-1:0] cur,
                        input bit may_idle);
        if (may_idle && !calm && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        push             <= 1'b1;
        frame_id         <= id;
        encoder_position <= pos;
        motor_speed      <= spd;
        motor_current    <= cur;
        do @(posedge clk); while (full);
    endtask

    // stop offering and let the pipeline run dry
    task automatic settle();
        push <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_INDEX_W-1:0] idx, input logic [ID_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_ids(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                               input logic [ID_W-1:0] c, input logic [ID_W-1:0] d,
                               input bit stray);
        settle();
        cfg_valid <= 1'b1;
        if (stray)
            cfg_beat(CFG_INDEX_W'($urandom_range(REG_COUNT, 2**CFG_INDEX_W - 1)),
                     ID_W'($urandom));
        cfg_beat(REG_MOTOR0_ID, a);
        cfg_beat(REG_MOTOR1_ID, b);
        cfg_beat(REG_MOTOR2_ID, c);
        cfg_beat(REG_MOTOR3_ID, d);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return -16'sd1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // mostly frames of configured motors with positions aimed at the wrap thresholds
    function automatic frame_t random_frame();
        frame_t f;
        int     m;
        int     last;
        int     p;
        m = $urandom_range(0, NUM_MOTORS - 1);
        if ($urandom_range(0, 9) < 7)
            f.id = sb.motor_id[m];
        else
            f.id = ID_W'($urandom);
        last = sb.last_pos[m];
        case ($urandom_range(0, 9))
            0, 1: p = $urandom_range(0, COUNTS_PER_TURN);
            2, 3, 4:
            begin
                p = last + int'($urandom_range(0, 400)) - 200;
                if (p < 0)
                    p = 0;
                if (p > COUNTS_PER_TURN)
                    p = COUNTS_PER_TURN;
            end
            5:
            begin
                if (last >= WRAP_HALF && $urandom_range(0, 1) == 1)
                    p = last - WRAP_HALF;
                else if (last + WRAP_HALF <= COUNTS_PER_TURN)
                    p = last + WRAP_HALF;
                else
                    p = last - WRAP_HALF;
            end
            6, 7:
            begin
                if (last <= COUNTS_PER_TURN - WRAP_HALF - 1)
                    p = $urandom_range(last + WRAP_HALF + 1, COUNTS_PER_TURN);
                else if (last >= WRAP_HALF + 1)
                    p = $urandom_range(0, last - WRAP_HALF - 1);
                else
                    p = $urandom_range(0, COUNTS_PER_TURN);
            end
            8: p = ($urandom_range(0, 1) == 1) ? COUNTS_PER_TURN : 0;
            default:
            begin
                if (last + WRAP_HALF + 1 <= COUNTS_PER_TURN)
                    p = last + WRAP_HALF + 1;
                else if (last >= WRAP_HALF + 1)
                    p = last - WRAP_HALF - 1;
                else
                    p = $urandom_range(0, COUNTS_PER_TURN);
            end
        endcase
        f.pos     = p[POS_W-1:0];
        f.speed   = pick_word();
        f.current = pick_word();
        return f;
    endfunction

    // three frames per turn: one jump past the threshold, two steps back under it
    task automatic spin_turns(input logic [ID_W-1:0] id, input bit downward);
        for (int t = 0; t < SPIN_TURNS; t++)
        begin
            send(id, downward ? POS_W'(5000) : POS_W'(0), pick_word(), pick_word(), 1'b0);
            send(id, POS_W'(2500), pick_word(), pick_word(), 1'b0);
            send(id, downward ? POS_W'(0) : POS_W'(5000), pick_word(), pick_word(), 1'b0);
        end
    endtask

    task automatic random_phase(input int phase);
        frame_t f;
        int     goal;
        int     n;
        bit     burst;
        goal  = sb.checked + sb.expected_results.size() + PHASE_RESULTS;
        n     = 0;
        burst = 1'b0;
        while (sb.checked + sb.expected_results.size() < goal)
        begin
            if (phase == 2 && n == 100)
            begin
                hold_req = 1'b1;
                while (!holding)
                    @(posedge clk);
                burst = 1'b1;
            end
            if (phase == 2 && n == 160)
                burst = 1'b0;
            if (phase == 3 && n == 100)
                settle();
            f = random_frame();
            send(f.id, f.pos, f.speed, f.current, !burst);
            n++;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset identifiers: misses, exact half-turn jumps, wraps both ways
        send(ID_W'(0), POS_W'(8191), 16'sd5, 16'sd6, 1'b1);
        send(ID_W'(2047), POS_W'(100), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(512), POS_W'(1), 16'sd1, 16'sd1, 1'b1);
        send(ID_W'(517), POS_W'(2), 16'sd2, 16'sd2, 1'b1);
        send(ID_W'(513), POS_W'(0), 16'sh7fff, 16'sh8000, 1'b1);
        send(ID_W'(513), POS_W'(4096), 16'sh8000, 16'sh7fff, 1'b1);
        send(ID_W'(513), POS_W'(0), -16'sd1, 16'sd0, 1'b1);
        send(ID_W'(513), POS_W'(4097), 16'sd0, -16'sd1, 1'b1);
        send(ID_W'(513), POS_W'(0), 16'sd100, -16'sd100, 1'b1);
        send(ID_W'(513), POS_W'(8191), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(513), POS_W'(8191), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(513), POS_W'(4095), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(513), POS_W'(0), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(514), POS_W'(8191), 16'sd1234, -16'sd1234, 1'b1);
        send(ID_W'(515), POS_W'(4097), 16'sh7fff, 16'sh7fff, 1'b1);
        send(ID_W'(516), POS_W'(4096), 16'sh8000, 16'sh8000, 1'b1);
        send(ID_W'(516), POS_W'(8191), -16'sd1, -16'sd1, 1'b1);
        send(ID_W'(516), POS_W'(0), 16'sd0, 16'sd0, 1'b1);

        // extreme identifiers
        program_ids(ID_W'(0), ID_W'(2047), ID_W'(1), ID_W'(2046), 1'b1);
        send(ID_W'(0), POS_W'(6000), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(2047), POS_W'(8191), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(1), POS_W'(0), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(2046), POS_W'(5000), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(513), POS_W'(5000), 16'sd0, 16'sd0, 1'b1);

        // duplicated identifiers resolve to the lower motor
        program_ids(ID_W'(5), ID_W'(5), ID_W'(7), ID_W'(7), 1'b0);
        send(ID_W'(5), POS_W'(7000), 16'sd0, 16'sd0, 1'b1);
        send(ID_W'(7), POS_W'(7000), 16'sd0, 16'sd0, 1'b1);

        // spin one motor down and another up through many turns, back to back
        calm = 1'b1;
        spin_turns(ID_W'(5), 1'b1);
        spin_turns(ID_W'(7), 1'b0);
        calm = 1'b0;

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 1)
                program_ids(ID_W'($urandom), ID_W'(9), ID_W'(9), ID_W'($urandom), 1'b1);
            else if (phase == 3)
                program_ids(ID_W'(2047), ID_W'(0), ID_W'($urandom), ID_W'(2047),
                            $urandom_range(0, 1));
            else
                program_ids(ID_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                            ID_W'($urandom), phase == 0 || $urandom_range(0, 1) == 1);
            if (phase == 4)
                calm = 1'b1;
            random_phase(phase);
        end

        push <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d frames (%0d unmatched), %0d results checked, %0d register writes",
                 sb.frames, sb.dropped, sb.checked, sb.reg_writes);
        $display("over %0d ID settings; turn counts ranged from %0d to %0d",
                 settings, sb.min_turns, sb.max_turns);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
